// ----- hdl/note_sine_tone_synth_assert.svh -----
// Assertion macros shared by the note synthesiser checkers.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef NOTE_SINE_TONE_SYNTH_ASSERT_SVH
`define NOTE_SINE_TONE_SYNTH_ASSERT_SVH

// implication in the same cycle, ignored while reset is low
`define NSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle, ignored while reset is low
`define NSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication in the next cycle, also checked through reset
`define NSS_ASSERT_RAW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/nss_pkg.sv -----
// Package for the note sine tone synthesiser: widths, codes, control structs,
// note frequency table and the sine table generator. No dependencies.
`default_nettype none

package nss_pkg;

    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_PHASE_BITS       = 32;

    localparam int SR_W       = 18;
    localparam int TEMPO_W    = 10;
    localparam int VOL_W      = 16;
    localparam int NOTE_W     = 7;
    localparam int TICKS_W    = 20;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 32;
    localparam int IN_DATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int DIV_NW     = 64;
    localparam int DIV_DW     = 48;
    localparam int BASE_W     = 28;
    localparam int OCT_W      = 4;

    localparam logic [SR_W-1:0]    SR_RESET    = 18'd44100;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 10'd120;
    localparam logic [VOL_W-1:0]   VOL_RESET   = 16'd16384;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE     = 2'd0,
        CFG_TEMPO           = 2'd1,
        CFG_MASTER_VOLUME   = 2'd2,
        CFG_ENVELOPE_ENABLE = 2'd3
    } t_cfg_idx;

    // commands from the controller to the datapath
    typedef struct packed {
        logic cap;         // capture input item
        logic nmul;        // ticks * sample rate
        logic n_ops;       // load divider operands for the sample count
        logic step_ops;    // load divider operands for the phase step
        logic amp_ops;     // load divider operands for the amplitude
        logic div_go;      // start the divider
        logic ld_n;        // store the sample count
        logic ld_step;     // store the phase step and arm the note
        logic rom_rd;      // read sine table, classify envelope segment
        logic mul1;        // magnitude * volume, pick gain
        logic ld_out;      // load the output item and advance the note
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic active;
        logic rest;
        logic div_done;
        logic out_free;
    } t_dp_sts;

    // notes 0..11 in Hz, unsigned Q24
    function automatic logic [BASE_W-1:0] base_freq_q24(input logic [OCT_W-1:0] semi);
        logic [BASE_W-1:0] f;
        case (semi)
            4'd0:    f = 28'd137167144;
            4'd1:    f = 28'd145323527;
            4'd2:    f = 28'd153964914;
            4'd3:    f = 28'd163120144;
            4'd4:    f = 28'd172819773;
            4'd5:    f = 28'd183096173;
            4'd6:    f = 28'd193983636;
            4'd7:    f = 28'd205518503;
            4'd8:    f = 28'd217739269;
            4'd9:    f = 28'd230686720;
            4'd10:   f = 28'd244404066;
            4'd11:   f = 28'd258937088;
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [OCT_W-1:0] note_octave(input logic [NOTE_W-1:0] note);
        logic [OCT_W-1:0] oct;
        oct = '0;
        for (int k = 1; k <= 10; k++) begin
            if (note >= NOTE_W'(12 * k)) begin
                oct = OCT_W'(k);
            end
        end
        return oct;
    endfunction

    function automatic logic [OCT_W-1:0] note_semitone(input logic [NOTE_W-1:0] note);
        logic [NOTE_W-1:0] r;
        r = note - NOTE_W'(note_octave(note)) * NOTE_W'(12);
        return r[OCT_W-1:0];
    endfunction

    // sin(u*pi/2), Q30 in and out, Taylor series to degree 11
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] u);
        logic [63:0] th, t2, a, one;
        one = 64'd1 << 30;
        th = (u * 64'd1686629713) >> 30;
        t2 = (th * th) >> 30;
        a  = one - t2 / 64'd110;
        a  = one - ((t2 * a) >> 30) / 64'd72;
        a  = one - ((t2 * a) >> 30) / 64'd42;
        a  = one - ((t2 * a) >> 30) / 64'd20;
        a  = one - ((t2 * a) >> 30) / 64'd6;
        return (th * a) >> 30;
    endfunction

    // one sine table entry; depth is 2**aw, evaluated at elaboration only
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int k, input int aw);
        logic [63:0] p, q, u, s, m;
        p = 64'(k) << 2;
        q = p >> aw;
        u = ((p & ((64'd1 << aw) - 64'd1)) << 30) >> aw;
        if (q[0]) begin
            u = (64'd1 << 30) - u;
        end
        s = quarter_sine_q30(u);
        m = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return (q >= 64'd2) ? -$signed(m[SAMPLE_W-1:0]) : $signed(m[SAMPLE_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/note_sine_tone_synth.sv -----
// Note sine tone synthesiser: DDS sine oscillator with a linear envelope.
// Top level; joins nss_ctrl and nss_dp, uses nss_pkg.
//
// Input stream (s_axis): tuser is the command, 0 starts a note, 1 asks for
// one sample. tdata carries note number, length in ticks and the rest flag.
// Output stream (m_axis): one signed 16-bit sample per tick while a note is
// active; tlast marks the final sample of the note. A tick with no active
// note gives no item. Settings go in through the write port i_cfg_*.
// One item is worked on at a time. After a start the input stays closed for
// two 64-step passes of the shared radix-2 divider (sample count, then
// phase step). A tick loads its sample after one divider pass for the
// envelope scaling, and the input stays closed until then; a rest tick skips
// the divider and a tick with no note only decodes before the input reopens.
// The next item is taken while a finished sample still waits in the output
// register; if the receiver stalls, a further tick holds in its last step
// until the register frees. Synchronous reset restores the default settings,
// drops any note and empties the output register. The sine table is a ROM.
`default_nettype none

module note_sine_tone_synth
    import nss_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = DEF_PHASE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // note_number [6:0], note_length_ticks [26:7], is_rest [27], zero [31:28]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd [0]
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // sample [15:0]
    output logic [SAMPLE_W-1:0]        m_axis_tdata,
    output logic                       m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    nss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nss_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- hdl/nss_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Uses nss_pkg for default widths.
`default_nettype none

module nss_div
    import nss_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem, r_den, n_rem;
    logic [NW-1:0] r_qn;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   rem_sh, rem_sub;
    logic          ge;

    always_comb begin
        rem_sh  = {r_rem, r_qn[NW-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
        n_rem   = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator and quotient share the shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_qn  <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_qn  <= {r_qn[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_qn;

endmodule

`default_nettype wire

// ----- hdl/nss_dp.sv -----
// Datapath of the note synthesiser: settings, note state, sine table,
// multipliers, shared divider and output register. Uses nss_pkg and nss_div.
`default_nettype none

module nss_dp
    import nss_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = DEF_PHASE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic                  i_in_kind,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [SAMPLE_W-1:0]        o_out_data,
    output logic                       o_out_last
);

    // table depth is a power of two
    localparam int AW  = $clog2(SINE_TABLE_DEPTH);
    localparam int PB  = PHASE_BITS;
    localparam int SHX = (PB >= 24) ? PB - 24 : 0;
    localparam int SHD = (PB >= 24) ? 0 : 24 - PB;

    // settings
    logic [SR_W-1:0]    r_sample_rate;
    logic [TEMPO_W-1:0] r_tempo;
    logic [VOL_W-1:0]   r_volume;
    logic               r_env_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= SR_RESET;
            r_tempo       <= TEMPO_RESET;
            r_volume      <= VOL_RESET;
            r_env_en      <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SAMPLE_RATE:     r_sample_rate <= i_cfg_data;
                CFG_TEMPO:           r_tempo       <= i_cfg_data[TEMPO_W-1:0];
                CFG_MASTER_VOLUME:   r_volume      <= i_cfg_data[VOL_W-1:0];
                CFG_ENVELOPE_ENABLE: r_env_en      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured item
    logic               r_kind, r_rest_in;
    logic [NOTE_W-1:0]  r_note;
    logic [TICKS_W-1:0] r_ticks;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind    <= i_in_kind;
            r_note    <= i_in_data[NOTE_W-1:0];
            r_ticks   <= i_in_data[NOTE_W +: TICKS_W];
            r_rest_in <= i_in_data[NOTE_W+TICKS_W];
        end
    end

    // zero tempo or sample rate counts as one
    logic [SR_W-1:0]    sr_eff;
    logic [TEMPO_W-1:0] tp_eff;
    assign sr_eff = (r_sample_rate == '0) ? SR_W'(1) : r_sample_rate;
    assign tp_eff = (r_tempo == '0) ? TEMPO_W'(1) : r_tempo;

    // divider operands
    logic [DIV_NW-1:0] r_num, div_quo, x_step;
    logic [DIV_DW-1:0] r_den, den_step;
    logic              div_done;
    logic [SR_W+TICKS_W-1:0] r_nprod;

    always_comb begin
        x_step   = (DIV_NW'(base_freq_q24(note_semitone(r_note))) << note_octave(r_note)) << SHX;
        den_step = DIV_DW'(sr_eff) << SHD;
    end

    // note state
    logic [PB-1:0]    r_phase, r_step;
    logic [CNT_W-1:0] r_index, r_nsamp;
    logic             r_rest, r_active;

    // envelope and amplitude
    logic signed [SAMPLE_W-1:0] r_sine;
    logic                       r_attack, r_release, r_neg, r_env;
    logic [CNT_W-1:0]           r_mag_vol, r_gain;
    logic [CNT_W+4:0]           i20;
    logic [CNT_W+3:0]           i10, n9;
    logic [SAMPLE_W-1:0]        mag;

    always_comb begin
        i20 = (CNT_W+5)'(r_index) * (CNT_W+5)'(20);
        i10 = (CNT_W+4)'(r_index) * (CNT_W+4)'(10);
        n9  = (CNT_W+4)'(r_nsamp) * (CNT_W+4)'(9);
        mag = r_sine[SAMPLE_W-1] ? SAMPLE_W'(-r_sine) : SAMPLE_W'(r_sine);
    end

    logic signed [SAMPLE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        assign sine_rom[k] = sine_entry(k, AW);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nmul) begin
            r_nprod <= (SR_W+TICKS_W)'(r_ticks) * (SR_W+TICKS_W)'(sr_eff);
        end
        if (i_cmd.n_ops) begin
            r_num <= DIV_NW'(r_nprod);
            r_den <= DIV_DW'({tp_eff, 3'b000});
        end
        if (i_cmd.step_ops) begin
            r_num <= x_step + DIV_NW'(den_step >> 1);
            r_den <= den_step;
        end
        if (i_cmd.amp_ops) begin
            r_num <= DIV_NW'(r_mag_vol) * DIV_NW'(r_gain);
            r_den <= r_env ? (DIV_DW'(r_nsamp) << 14) : (DIV_DW'(1) << 14);
        end
        if (i_cmd.rom_rd) begin
            r_sine    <= sine_rom[r_phase[PB-1 -: AW]];
            r_attack  <= r_env_en && (i20 < (CNT_W+5)'(r_nsamp));
            r_release <= r_env_en && !(i20 < (CNT_W+5)'(r_nsamp)) && (i10 > n9);
        end
        if (i_cmd.mul1) begin
            r_mag_vol <= CNT_W'(mag) * CNT_W'(r_volume);
            r_neg     <= r_sine[SAMPLE_W-1];
            r_env     <= r_attack || r_release;
            if (r_attack) begin
                r_gain <= i20[CNT_W-1:0];
            end else if (r_release) begin
                r_gain <= CNT_W'((CNT_W+4)'(r_nsamp - r_index) * (CNT_W+4)'(10));
            end else begin
                r_gain <= CNT_W'(1);
            end
        end
    end

    nss_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // saturated sample from the amplitude quotient
    logic [SAMPLE_W-1:0] n_sample;
    logic [CNT_W:0]      idx_inc;
    logic                last;

    always_comb begin
        if (r_rest) begin
            n_sample = '0;
        end else if (r_neg) begin
            n_sample = (div_quo > DIV_NW'(32768)) ? 16'h8000
                                                  : SAMPLE_W'(-{1'b0, div_quo[SAMPLE_W-1:0]});
        end else begin
            n_sample = (div_quo > DIV_NW'(32767)) ? 16'h7fff : div_quo[SAMPLE_W-1:0];
        end
        idx_inc = (CNT_W+1)'(r_index) + (CNT_W+1)'(1);
        last    = idx_inc >= (CNT_W+1)'(r_nsamp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_step   <= '0;
            r_index  <= '0;
            r_nsamp  <= '0;
            r_rest   <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_cmd.ld_n) begin
                // clamp to one and to the 32-bit ceiling
                if (div_quo > DIV_NW'({CNT_W{1'b1}})) begin
                    r_nsamp <= '1;
                end else if (div_quo == '0) begin
                    r_nsamp <= CNT_W'(1);
                end else begin
                    r_nsamp <= div_quo[CNT_W-1:0];
                end
            end
            if (i_cmd.ld_step) begin
                r_step   <= div_quo[PB-1:0];
                r_phase  <= '0;
                r_index  <= '0;
                r_rest   <= r_rest_in;
                r_active <= 1'b1;
            end
            if (i_cmd.ld_out) begin
                r_phase <= r_phase + r_step;
                r_index <= idx_inc[CNT_W-1:0];
                if (last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // output register
    logic                r_out_valid, r_out_last;
    logic [SAMPLE_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_data <= n_sample;
            r_out_last <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    always_comb begin
        o_sts.kind     = r_kind;
        o_sts.active   = r_active;
        o_sts.rest     = r_rest;
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire

// ----- hdl/nss_ctrl.sv -----
// Controller of the note synthesiser: sequences capture, division and output.
// Uses nss_pkg for the command and status structs.
`default_nettype none

module nss_ctrl
    import nss_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_NOPS, S_NDIV, S_NWAIT, S_SOPS, S_SDIV, S_SWAIT,
        S_MUL1, S_MUL2, S_ADIV, S_AWAIT, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.kind == CMD_START) begin
                    o_cmd.nmul = 1'b1;
                    n_state    = S_NOPS;
                end else if (!i_sts.active) begin
                    n_state = S_IDLE;
                end else if (i_sts.rest) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.rom_rd = 1'b1;
                    n_state      = S_MUL1;
                end
            end
            S_NOPS: begin
                o_cmd.n_ops = 1'b1;
                n_state     = S_NDIV;
            end
            S_NDIV: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_NWAIT;
            end
            S_NWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_n = 1'b1;
                    n_state    = S_SOPS;
                end
            end
            S_SOPS: begin
                o_cmd.step_ops = 1'b1;
                n_state        = S_SDIV;
            end
            S_SDIV: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_step = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.amp_ops = 1'b1;
                n_state       = S_ADIV;
            end
            S_ADIV: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_AWAIT;
            end
            S_AWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register can take the item
                if (i_sts.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/nss_checker.sv -----
// Port-level checks for note_sine_tone_synth, bound to the top level.
// Uses nss_pkg and the assertion macros header.
`default_nettype none
`include "note_sine_tone_synth_assert.svh"

module nss_checker
    import nss_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [SAMPLE_W-1:0]   m_axis_tdata,
    input wire logic                  m_axis_tlast
);

    `NSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output item changed")
    `NSS_ASSERT_RAW(a_rst_empty, !i_rst_n, !m_axis_tvalid, "output valid after reset")
    `NSS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")
    `NSS_ASSERT_NEXT(a_start_quiet, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_START && !m_axis_tvalid, !m_axis_tvalid, "start produced an output item")

endmodule

bind note_sine_tone_synth nss_checker u_nss_checker (.*);

`default_nettype wire

// ----- tb/note_sine_tone_synth_checker.sv -----
// Checker for note_sine_tone_synth: watches the write port and both streams,
// predicts every sample and compares it with what the block sends. Uses nss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module note_sine_tone_synth_checker
    import nss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic                  i_in_cmd,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [SAMPLE_W-1:0]   i_out_data,
    input  wire logic                  i_out_last,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_samples
);

    typedef struct {
        logic [SAMPLE_W-1:0] pcm;
        logic                last;
    } pcm_item_t;

    logic signed [SAMPLE_W-1:0] sine_rom [0:1023];
    logic [27:0] semitone_hz_q24 [0:11];

    pcm_item_t   expected_pcm [$];
    logic [17:0] rate;
    logic [9:0]  bpm;
    logic [15:0] gain;
    logic        env_on;
    logic [31:0] phase, phase_inc, pos, length;
    logic        resting, playing;

    // sin(u*pi/2) on the quarter wave, Q30 in and out
    function automatic logic [63:0] quarter_wave_q30(input logic [63:0] u);
        logic [63:0] th, t2, a;
        th = (u * 64'd1686629713) >> 30;
        t2 = (th * th) >> 30;
        a  = (64'd1 << 30) - t2 / 64'd110;
        a  = (64'd1 << 30) - ((t2 * a) >> 30) / 64'd72;
        a  = (64'd1 << 30) - ((t2 * a) >> 30) / 64'd42;
        a  = (64'd1 << 30) - ((t2 * a) >> 30) / 64'd20;
        a  = (64'd1 << 30) - ((t2 * a) >> 30) / 64'd6;
        return (th * a) >> 30;
    endfunction

    initial begin
        logic [63:0] p, q, u, m;
        semitone_hz_q24 = '{28'd137167144, 28'd145323527, 28'd153964914, 28'd163120144,
                            28'd172819773, 28'd183096173, 28'd193983636, 28'd205518503,
                            28'd217739269, 28'd230686720, 28'd244404066, 28'd258937088};
        for (int k = 0; k < 1024; k++) begin
            p = 64'(k) * 4;
            q = p / 1024;
            u = ((p % 1024) << 30) / 1024;
            if (q[0]) begin
                u = (64'd1 << 30) - u;
            end
            m = (quarter_wave_q30(u) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (m > 64'd32767) begin
                m = 64'd32767;
            end
            sine_rom[k] = (q >= 2) ? -$signed(m[15:0]) : $signed(m[15:0]);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    task automatic begin_note(input logic [IN_DATA_W-1:0] d);
        logic [63:0] sr, tp, n, x;
        sr = (rate == 0) ? 64'd1 : 64'(rate);
        tp = (bpm == 0) ? 64'd1 : 64'(bpm);
        n  = (64'(d[26:7]) * sr) / (8 * tp);
        if (n < 1) begin
            n = 1;
        end
        if (n > 64'hFFFF_FFFF) begin
            n = 64'hFFFF_FFFF;
        end
        x = (64'(semitone_hz_q24[d[6:0] % 12]) << (d[6:0] / 12)) << 8;
        phase_inc = 32'((x + sr / 2) / sr);
        phase     = '0;
        pos       = '0;
        length    = n[31:0];
        resting   = d[27];
        playing   = 1'b1;
    endtask

    task automatic predict_sample();
        logic [63:0] i, n, mag, num, den, q;
        logic signed [15:0] t;
        int val;
        pcm_item_t e;
        if (!playing) begin
            return;
        end
        i = 64'(pos);
        n = 64'(length);
        val = 0;
        if (!resting) begin
            t   = sine_rom[phase[31:22]];
            mag = (t < 0) ? 64'(-32'(t)) : 64'(t);
            num = mag * 64'(gain);
            den = 64'd16384;
            if (env_on) begin
                if (20 * i < n) begin
                    num = num * (20 * i);
                    den = den * n;
                end else if (10 * i > 9 * n) begin
                    num = num * (10 * (n - i));
                    den = den * n;
                end
            end
            q = num / den;
            if (t < 0) begin
                val = (q > 32768) ? -32768 : -int'(q);
            end else begin
                val = (q > 32767) ? 32767 : int'(q);
            end
        end
        phase  = phase + phase_inc;
        e.pcm  = val[15:0];
        e.last = (i + 1 >= n);
        pos    = pos + 1;
        if (e.last) begin
            playing = 1'b0;
        end
        expected_pcm = {expected_pcm, e};
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate    = SR_RESET;
            bpm     = TEMPO_RESET;
            gain    = VOL_RESET;
            env_on  = 1'b1;
            phase   = '0;
            phase_inc = '0;
            pos     = '0;
            length  = '0;
            resting = 1'b0;
            playing = 1'b0;
            o_errors  = 0;
            o_samples = 0;
            expected_pcm.delete();
        end else begin
            // results first: anything leaving now belongs to an older item
            if (i_out_valid && i_out_ready) begin
                if (expected_pcm.size() == 0) begin
                    report_mismatch("unexpected item, tdata", int'($signed(i_out_data)), 0);
                end else begin
                    pcm_item_t e;
                    e = expected_pcm.pop_front();
                    o_samples++;
                    if (i_out_data !== e.pcm) begin
                        report_mismatch("sample", int'($signed(i_out_data)),
                                        int'($signed(e.pcm)));
                    end
                    if (i_out_last !== e.last) begin
                        report_mismatch("tlast", int'(i_out_last), int'(e.last));
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SAMPLE_RATE:     rate   = i_cfg_data[17:0];
                    CFG_TEMPO:           bpm    = i_cfg_data[9:0];
                    CFG_MASTER_VOLUME:   gain   = i_cfg_data[15:0];
                    CFG_ENVELOPE_ENABLE: env_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_cmd == CMD_START) begin
                    begin_note(i_in_data);
                end else begin
                    predict_sample();
                end
            end
        end
        o_pending = expected_pcm.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb_note_sine_tone_synth.sv -----
// Testbench top for note_sine_tone_synth: drives notes, ticks and settings,
// and gives the verdict. Needs nss_pkg, the block and note_sine_tone_synth_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_note_sine_tone_synth;
    import nss_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;

    int   errors, pending, samples;
    int   cycles = 0;
    int   items_sent = 0;
    int   notes_sent = 0;
    logic gaps_on = 1'b1;
    logic hold_req = 1'b0;
    logic [17:0] rate_now = 18'd44100;
    logic [9:0]  bpm_now = 10'd120;

    note_sine_tone_synth dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    note_sine_tone_synth_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_cmd    (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_last  (m_axis_tlast),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_samples   (samples)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req <= 1'b0;
                m_axis_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= i_rst_n;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] d);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_start(input logic [6:0] note, input logic [19:0] ticks,
                              input logic rest);
        send_item(CMD_START, {4'b0, rest, ticks, note});
        notes_sent++;
    endtask

    task automatic send_ticks(input int count);
        for (int k = 0; k < count; k++) begin
            send_item(CMD_TICK, IN_DATA_W'($urandom));
        end
    endtask

    // ticks giving roughly the wanted sample count at the current settings
    function automatic logic [19:0] ticks_for(input int want);
        longint sr, tp, t;
        sr = (rate_now == 0) ? 1 : longint'(rate_now);
        tp = (bpm_now == 0) ? 1 : longint'(bpm_now);
        t  = (longint'(want) * 8 * tp + sr - 1) / sr;
        return (t > 1048575) ? 20'hFFFFF : 20'(t);
    endfunction

    // hold off until every sample is out and any start has finished
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [17:0] sr, input logic [9:0] tp,
                              input logic [15:0] vol, input logic env);
        drain();
        write_reg(CFG_SAMPLE_RATE, sr);
        write_reg(CFG_TEMPO, CFG_DATA_W'(tp));
        write_reg(CFG_MASTER_VOLUME, CFG_DATA_W'(vol));
        write_reg(CFG_ENVELOPE_ENABLE, CFG_DATA_W'(env));
        i_cfg_we <= 1'b0;
        rate_now = sr;
        bpm_now  = tp;
    endtask

    task automatic random_notes(input int quota);
        int stop_at, want, count, pick;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                send_ticks($urandom_range(1, 3));
            end else if (pick == 1) begin
                send_start(7'($urandom_range(0, 127)), 20'($urandom),
                           1'($urandom_range(0, 1)));
                send_ticks($urandom_range(0, 6));
            end else begin
                want  = $urandom_range(1, 40);
                count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, want - 1)
                                                   : want + $urandom_range(0, 2);
                send_start(7'($urandom_range(0, 127)), ticks_for(want),
                           $urandom_range(0, 5) == 0);
                send_ticks(count);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, at reset settings
        send_ticks(1);                       // idle tick
        send_start(7'd0, 20'd0, 1'b0);       // zero length gives one sample
        send_ticks(2);
        send_start(7'd127, 20'd1, 1'b0);     // top note
        send_ticks(3);
        send_start(7'd69, 20'd0, 1'b1);      // rest replaces the active note
        send_ticks(1);
        send_start(7'd60, 20'hFFFFF, 1'b0);  // longest length
        send_ticks(4);
        send_start(7'd12, 20'd1, 1'b1);
        send_ticks(3);
        send_start(7'd81, 20'd0, 1'b0);
        send_ticks(2);

        set_config(18'd8000, 10'd1000, 16'd16384, 1'b1);
        // long receiver hold while ticks keep coming
        send_start(7'd69, ticks_for(60), 1'b0);
        hold_req <= 1'b1;
        send_ticks(60);
        random_notes(250);

        set_config(18'd8000, 10'd1000, 16'hFFFF, 1'b1);  // saturating gain
        random_notes(250);
        set_config(18'd192000, 10'd1000, 16'd0, 1'b0);
        random_notes(150);
        set_config(18'h3FFFF, 10'h3FF, 16'd40000, 1'b0);
        random_notes(200);
        set_config(18'd0, 10'd0, 16'd30000, 1'b1);        // zero rate and tempo
        random_notes(200);
        set_config(18'd12345, 10'd1, 16'd20000, 1'b1);
        send_start(7'd100, 20'hFFFFF, 1'b0);              // longest length
        send_ticks(5);
        random_notes(150);
        set_config(18'($urandom_range(8000, 48000)), 10'($urandom_range(500, 1000)),
                   16'($urandom), 1'b1);
        random_notes(200);

        set_config(18'd8000, 10'd1000, 16'd24000, 1'b1);
        gaps_on <= 1'b0;
        random_notes(200);
        drain();

        $display("covered %0d input items in %0d notes, %0d samples checked",
                 items_sent, notes_sent, samples);
        $display("settings: eight, incl. zero/max rate and tempo, gain 0..65535, envelope on/off");
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
